FILE: rtl/core/sync_framed_fletcher_packet_receiver_core_macros.svh
// Assertion macros for the sync-framed packet receiver core.
`ifndef SYNC_FRAMED_FLETCHER_PACKET_RECEIVER_CORE_MACROS_SVH
`define SYNC_FRAMED_FLETCHER_PACKET_RECEIVER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property holds in the same cycle as its trigger.
`define SFPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfpr assertion failed");

// Property holds in the cycle after its trigger.
`define SFPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfpr assertion failed");

`else

`define SFPR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SFPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/sfpr_pkg.sv
// Package with constants and types shared by the packet receiver modules.
`default_nettype none

package sfpr_pkg;

  // Packet body length, check word included.
  localparam int unsigned PacketBytes = 16;
  localparam int unsigned IdxW        = 6;

  localparam logic [IdxW-1:0] LastIdx     = IdxW'(PacketBytes - 1);
  localparam logic [IdxW-1:0] LowCheckIdx = IdxW'(PacketBytes - 2);

  // Sync character and the sums seeded from the sync pair.
  localparam logic [7:0] SyncChar   = 8'h7E;
  localparam logic [7:0] SeedFirst  = 8'(SyncChar + SyncChar);
  localparam logic [7:0] SeedSecond = 8'(SyncChar + SeedFirst);

  // One result transaction.
  typedef struct packed {
    logic [7:0]      data_byte;
    logic [IdxW-1:0] byte_index;
    logic            last;
    logic            checksum_ok;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/sfpr_in_stage.sv
// Input register that holds one received byte until the framer takes it.
`default_nettype none

module sfpr_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  output logic       stall_o,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);
  import sfpr_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // Accept a new transaction whenever the held byte is empty or leaves now.
  assign stall_o = valid_q & ~take_i;
  assign load    = valid_i & ~stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

FILE: rtl/core/sfpr_framer.sv
// Sync hunt, body counting and Fletcher-style check, one byte per cycle while take_i is high.
`default_nettype none

module sfpr_framer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       byte_i,
  input  logic             take_i,
  output logic             emit_o,
  output sfpr_pkg::result_t result_o
);
  import sfpr_pkg::*;

  logic            hunting_q, hunting_d;
  logic [IdxW-1:0] count_q, count_d;
  logic [7:0]      prev_q, prev_d;
  logic [7:0]      sum1_q, sum1_d;
  logic [7:0]      sum2_q, sum2_d;
  logic            lowok_q, lowok_d;
  logic            is_last;

  assign is_last = (count_q >= LastIdx);

  // Bytes seen while hunting give no result.
  assign emit_o = ~hunting_q;

  assign result_o.data_byte   = byte_i;
  assign result_o.byte_index  = count_q;
  assign result_o.last        = is_last;
  assign result_o.checksum_ok = is_last & lowok_q & (byte_i == sum2_q);

  // Next state for the byte taken this cycle.
  always_comb begin
    hunting_d = hunting_q;
    count_d   = count_q;
    prev_d    = prev_q;
    sum1_d    = sum1_q;
    sum2_d    = sum2_q;
    lowok_d   = lowok_q;
    if (take_i) begin
      if (hunting_q) begin
        if ((prev_q == SyncChar) && (byte_i == SyncChar)) begin
          hunting_d = 1'b0;
          count_d   = '0;
          sum1_d    = SeedFirst;
          sum2_d    = SeedSecond;
          lowok_d   = 1'b0;
        end else begin
          prev_d = byte_i;
        end
      end else begin
        if (count_q < LowCheckIdx) begin
          sum1_d = sum1_q + byte_i;
          sum2_d = sum2_q + sum1_d;
        end else if (count_q == LowCheckIdx) begin
          lowok_d = (byte_i == sum1_q);
        end
        if (is_last) begin
          hunting_d = 1'b1;
          prev_d    = '0;
          count_d   = '0;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q <= 1'b1;
      count_q   <= '0;
      prev_q    <= '0;
      sum1_q    <= SeedFirst;
      sum2_q    <= SeedSecond;
      lowok_q   <= 1'b0;
    end else begin
      hunting_q <= hunting_d;
      count_q   <= count_d;
      prev_q    <= prev_d;
      sum1_q    <= sum1_d;
      sum2_q    <= sum2_d;
      lowok_q   <= lowok_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sfpr_out_stage.sv
// Result register that holds one result transaction until it is taken.
`default_nettype none

module sfpr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sfpr_pkg::result_t result_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              stall_i,
  output sfpr_pkg::result_t result_o
);
  import sfpr_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // The register can load when it is empty or its content leaves now.
  assign ready_o = ~valid_q | ~stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

FILE: rtl/core/sync_framed_fletcher_packet_receiver_core.sv
// Top level of the sync-framed packet receiver with Fletcher-style check.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid_i/in_stall_o | rx_byte_i
//   out     | output    | out_valid_o/out_stall_i | data_byte_o, byte_index_o, last_o,
//           |           |                      | checksum_ok_o
//
// A body byte accepted into the input register moves into the result register once that
// has room, and its result is offered from there; one byte per cycle is sustained while the
// output is not stalled, as the sums and the body counter update once per byte taken.
// Reset is asynchronous and active low; afterwards the block hunts for sync.
// While hunting, bytes are consumed even if the output is stalled; a packet body
// byte waits in the input register while the result register is full and stalled.
`default_nettype none
`include "sync_framed_fletcher_packet_receiver_core_macros.svh"

module sync_framed_fletcher_packet_receiver_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  data_byte_o,
  output logic [sfpr_pkg::IdxW-1:0]   byte_index_o,
  output logic                        last_o,
  output logic                        checksum_ok_o
);
  import sfpr_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte;
  logic       take;
  logic       emit;
  logic       out_ready;
  result_t    fr_result;
  result_t    out_result;

  // Input register.
  sfpr_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .byte_i  (rx_byte_i),
    .stall_o (in_stall_o),
    .take_i  (take),
    .valid_o (in_valid_q),
    .byte_o  (in_byte)
  );

  // The held byte moves on when its result has room, or when it gives none.
  assign take = in_valid_q & (out_ready | ~emit);

  // Framing and checksum logic.
  sfpr_framer u_framer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (in_byte),
    .take_i   (take),
    .emit_o   (emit),
    .result_o (fr_result)
  );

  // Result register.
  sfpr_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (take & emit),
    .result_i (fr_result),
    .ready_o  (out_ready),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .result_o (out_result)
  );

  assign data_byte_o   = out_result.data_byte;
  assign byte_index_o  = out_result.byte_index;
  assign last_o        = out_result.last;
  assign checksum_ok_o = out_result.checksum_ok;

  // A passed check is only ever flagged on the final byte of a packet.
  `SFPR_ASSERT_SAME(a_ok_only_on_last, clk_i, rst_ni, out_valid_o && checksum_ok_o, last_o)
  // The final byte always carries the last body position.
  `SFPR_ASSERT_SAME(a_last_index, clk_i, rst_ni, out_valid_o && last_o, byte_index_o == LastIdx)
  // The input side stalls only while it holds a byte that cannot move.
  `SFPR_ASSERT_SAME(a_stall_holds, clk_i, rst_ni, in_stall_o, in_valid_q && !take)
  // A packet byte taken into a free result register shows up as a valid result.
  `SFPR_ASSERT_NEXT(a_emit_loads, clk_i, rst_ni, take && emit, out_valid_o)

endmodule

`default_nettype wire

FILE: bench/sync_framed_fletcher_packet_receiver_core_tb.sv
// Self-checking testbench for the sync-framed packet receiver with Fletcher-style check.
module sync_framed_fletcher_packet_receiver_core_tb;
  import sfpr_pkg::*;

  localparam int unsigned CycleLimit      = 200000;
  localparam int unsigned RandomBodyBytes = 384;
  localparam int unsigned MaxPrinted      = 40;
  localparam int unsigned DirRows         = 22;

  // One directed stimulus row; typed rows carry their expected outcome.
  typedef struct {
    logic [7:0] rx;
    bit         typed;
    bit         gives;
    result_t    res;
  } dir_row_t;

  logic            clk_i  = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [7:0]      rx_byte_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [7:0]      data_byte_o;
  logic [IdxW-1:0] byte_index_o;
  logic            last_o;
  logic            checksum_ok_o;

  // Deframer state as predicted from the accepted byte stream.
  logic            hunt_q      = 1'b1;
  logic [IdxW-1:0] body_idx_q  = '0;
  logic [7:0]      prev_byte_q = 8'h00;
  logic [7:0]      fsum_lo_q   = SeedFirst;
  logic [7:0]      fsum_hi_q   = SeedSecond;
  logic            lo_check_q  = 1'b0;

  result_t         pending_results [$];
  dir_row_t        dir_rows [DirRows];
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;
  bit              send_quiet  = 1'b0;
  bit              recv_quiet  = 1'b0;

  sync_framed_fletcher_packet_receiver_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .last_o        (last_o),
    .checksum_ok_o (checksum_ok_o)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** sync_framed_fletcher_packet_receiver_core: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxPrinted) $display("cycle %0d: mismatch: %s", cycle_count, msg);
  endtask

  // Advances the predicted deframer by one byte and returns the result it gives, if any.
  task automatic deframe_predict(input logic [7:0] b, output bit got, output result_t res);
    got = 1'b0;
    res = '0;
    if (hunt_q) begin
      // A second sync byte in a row opens a body; anything else is remembered.
      if (prev_byte_q == SyncChar && b == SyncChar) begin
        hunt_q     = 1'b0;
        body_idx_q = '0;
        fsum_lo_q  = SeedFirst;
        fsum_hi_q  = SeedSecond;
        lo_check_q = 1'b0;
      end else begin
        prev_byte_q = b;
      end
    end else begin
      got = 1'b1;
      res.data_byte  = b;
      res.byte_index = body_idx_q;
      if (32'(body_idx_q) + 2 < PacketBytes) begin
        fsum_lo_q = fsum_lo_q + b;
        fsum_hi_q = fsum_hi_q + fsum_lo_q;
      end else if (32'(body_idx_q) + 2 == PacketBytes) begin
        lo_check_q = (b == fsum_lo_q);
      end
      // The final byte closes the packet and the search restarts from a cleared byte.
      if (32'(body_idx_q) + 1 >= PacketBytes) begin
        res.last        = 1'b1;
        res.checksum_ok = lo_check_q && (b == fsum_hi_q);
        hunt_q          = 1'b1;
        prev_byte_q     = 8'h00;
        body_idx_q      = '0;
      end else begin
        body_idx_q = body_idx_q + 1'b1;
      end
    end
  endtask

  // Sends one byte after a random gap, waits for the transaction and predicts its outcome.
  task automatic deliver_byte(input logic [7:0] b, output bit got, output result_t res);
    int unsigned gap;
    if ($urandom_range(0, 9) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    deframe_predict(b, got, res);
  endtask

  task automatic feed_byte(input logic [7:0] b);
    bit      got;
    result_t res;
    deliver_byte(b, got, res);
    if (got) pending_results.push_back(res);
  endtask

  // Stimulus: directed rows first, then random packets.
  initial begin
    bit          got;
    result_t     res;
    logic [7:0]  noise;
    logic [7:0]  b;
    logic [7:0]  sum_lo;
    logic [7:0]  sum_hi;
    int unsigned body_total;

    in_valid_i <= 1'b0;
    rx_byte_i  <= 8'h00;

    // A broken sync pair, a real one, sync bytes as body data, extreme bytes,
    // a packet whose last byte is a sync byte, and then a lone sync byte
    // that must not pair with it.
    dir_rows = '{
      '{8'h7E, 1'b1, 1'b0, result_t'('0)},
      '{8'h41, 1'b1, 1'b0, result_t'('0)},
      '{8'h7E, 1'b1, 1'b0, result_t'('0)},
      '{8'h7E, 1'b1, 1'b0, result_t'('0)},
      '{8'h7E, 1'b1, 1'b1, '{8'h7E, 6'd0, 1'b0, 1'b0}},
      '{8'h7E, 1'b1, 1'b1, '{8'h7E, 6'd1, 1'b0, 1'b0}},
      '{8'h00, 1'b1, 1'b1, '{8'h00, 6'd2, 1'b0, 1'b0}},
      '{8'hFF, 1'b1, 1'b1, '{8'hFF, 6'd3, 1'b0, 1'b0}},
      '{8'h01, 1'b0, 1'b0, result_t'('0)},
      '{8'h80, 1'b0, 1'b0, result_t'('0)},
      '{8'h55, 1'b0, 1'b0, result_t'('0)},
      '{8'hAA, 1'b0, 1'b0, result_t'('0)},
      '{8'h7F, 1'b0, 1'b0, result_t'('0)},
      '{8'hFE, 1'b0, 1'b0, result_t'('0)},
      '{8'h12, 1'b0, 1'b0, result_t'('0)},
      '{8'h34, 1'b0, 1'b0, result_t'('0)},
      '{8'hC3, 1'b0, 1'b0, result_t'('0)},
      '{8'h3C, 1'b0, 1'b0, result_t'('0)},
      '{8'h00, 1'b0, 1'b0, result_t'('0)},
      '{8'h7E, 1'b0, 1'b0, result_t'('0)},
      '{8'h7E, 1'b1, 1'b0, result_t'('0)},
      '{8'h00, 1'b1, 1'b0, result_t'('0)}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      deliver_byte(dir_rows[i].rx, got, res);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].gives) pending_results.push_back(dir_rows[i].res);
      end else if (got) begin
        pending_results.push_back(res);
      end
    end

    // Random packets: noise, a sync pair, a random body and a check word that is correct in about half of them.
    body_total = 0;
    while (body_total < RandomBodyBytes) begin
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 1) == 1) feed_byte(SyncChar);
        noise = 8'($urandom_range(0, 255));
        if (noise == SyncChar) noise = 8'h00;
        feed_byte(noise);
      end
      feed_byte(SyncChar);
      feed_byte(SyncChar);
      sum_lo = SeedFirst;
      sum_hi = SeedSecond;
      for (int i = 0; i < int'(PacketBytes) - 2; i++) begin
        b = ($urandom_range(0, 7) == 0) ? SyncChar : 8'($urandom_range(0, 255));
        sum_lo = sum_lo + b;
        sum_hi = sum_hi + sum_lo;
        feed_byte(b);
      end
      // Corrupt the low half, the high half or both in some packets.
      case ($urandom_range(0, 5))
        3: sum_lo = sum_lo ^ 8'($urandom_range(1, 255));
        4: sum_hi = sum_hi ^ 8'($urandom_range(1, 255));
        5: begin
          sum_lo = 8'($urandom_range(0, 255));
          sum_hi = 8'($urandom_range(0, 255));
        end
        default: ;
      endcase
      feed_byte(sum_lo);
      feed_byte(sum_hi);
      body_total += PacketBytes;
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** sync_framed_fletcher_packet_receiver_core: PASSED **");
    end else begin
      $display("** sync_framed_fletcher_packet_receiver_core: FAILED **");
    end
    $finish;
  end

  // Result side: random stalls, then each transaction is checked against the oldest prediction.
  initial begin
    result_t     want;
    int unsigned stall_n;
    out_stall_i <= 1'b0;
    forever begin
      if ($urandom_range(0, 9) == 0) recv_quiet = !recv_quiet;
      stall_n = recv_quiet ? 0 : $urandom_range(0, 4);
      if (stall_n != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result data %02h index %0d",
                                  data_byte_o, byte_index_o));
      end else begin
        want = pending_results.pop_front();
        if (data_byte_o !== want.data_byte)
          report_mismatch($sformatf("data_byte %02h, predicted %02h",
                                    data_byte_o, want.data_byte));
        if (byte_index_o !== want.byte_index)
          report_mismatch($sformatf("byte_index %0d, predicted %0d",
                                    byte_index_o, want.byte_index));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %b, predicted %b at index %0d",
                                    last_o, want.last, want.byte_index));
        if (checksum_ok_o !== want.checksum_ok)
          report_mismatch($sformatf("checksum_ok %b, predicted %b at index %0d",
                                    checksum_ok_o, want.checksum_ok, want.byte_index));
      end
    end
  end

endmodule

FILE: sync_framed_fletcher_packet_receiver_core.f
+incdir+rtl/core
rtl/core/sfpr_pkg.sv
rtl/core/sfpr_in_stage.sv
rtl/core/sfpr_framer.sv
rtl/core/sfpr_out_stage.sv
rtl/core/sync_framed_fletcher_packet_receiver_core.sv
bench/sync_framed_fletcher_packet_receiver_core_tb.sv
